>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types, constants and helpers for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkv_pkg;

   // store geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // field widths
   localparam int CAP_W  = 5;
   localparam int DATA_W = 32;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [CAP_W-1:0]         cap_type;
   typedef logic signed [DATA_W-1:0] data_type;

   // capacity after reset
   localparam cap_type CAP_RESET = cap_type'(16);

   // returned on a miss
   localparam data_type MISS_VALUE = data_type'(-1);

   // request commands
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   // table update kinds
   typedef enum logic [1:0] {
      OP_NONE,
      OP_PROMOTE,
      OP_INSERT
   } op_type;

   // update handed from the sequencer to the table
   typedef struct packed {
      logic     valid;
      op_type   op;
      idx_type  slot;
      data_type key;
      data_type value;
      logic     write_value;
      logic     evict;
      idx_type  cap_m1;
      cnt_type  count;
   } commit_type;

   // table state seen by the sequencer
   typedef struct packed {
      logic [ENTRIES-1:0]    valid;
      idx_type [ENTRIES-1:0] rank;
      cnt_type               occupancy;
   } status_type;

   // capacity minus one, with zero taken as one and large values saturated
   function automatic idx_type eff_cap_m1(input cap_type c);
      if (c == '0) begin
         return '0;
      end else if (int'(c) >= ENTRIES) begin
         return IDX_W'(ENTRIES - 1);
      end else begin
         return IDX_W'(c - 1'b1);
      end
   endfunction

endpackage

>>> rtl/lkv_if.sv
// ----------------------------------------------------------------------------
// lkv_if
// Valid/ready channels carrying cache requests and lookup responses.
// ----------------------------------------------------------------------------

// request channel
interface lkv_req_if;
   logic              valid;
   logic              ready;
   logic              command;
   lkv_pkg::data_type lookup_key;
   lkv_pkg::data_type store_value;

   modport source (output valid, output command, output lookup_key,
                   output store_value, input ready);
   modport sink   (input valid, input command, input lookup_key,
                   input store_value, output ready);
endinterface

// response channel
interface lkv_rsp_if;
   logic              valid;
   logic              ready;
   logic              hit;
   lkv_pkg::data_type read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

>>> rtl/lkv_table.sv
// ----------------------------------------------------------------------------
// lkv_table
// Key/value memories with one read and one write port, plus valid bits,
// recency ranks and occupancy count updated at commit.
// ----------------------------------------------------------------------------
module lkv_table (
   input  logic                   clock,
   input  logic                   reset,
   input  lkv_pkg::idx_type       rd_addr,
   output lkv_pkg::data_type      rd_key,
   output lkv_pkg::data_type      rd_value,
   input  lkv_pkg::commit_type    commit,
   output lkv_pkg::status_type    status
);

   lkv_pkg::data_type key_mem   [lkv_pkg::ENTRIES];
   lkv_pkg::data_type value_mem [lkv_pkg::ENTRIES];
   lkv_pkg::data_type rd_key_ff;
   lkv_pkg::data_type rd_value_ff;

   logic [lkv_pkg::ENTRIES-1:0]            valid_ff, valid_in;
   lkv_pkg::idx_type [lkv_pkg::ENTRIES-1:0] rank_ff, rank_in;
   lkv_pkg::cnt_type                       occ_ff, occ_in;

   logic do_insert;
   logic do_value;

   assign do_insert = commit.valid && (commit.op == lkv_pkg::OP_INSERT);
   assign do_value  = do_insert ||
                      (commit.valid && (commit.op == lkv_pkg::OP_PROMOTE) &&
                       commit.write_value);

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (do_insert) begin
         key_mem[commit.slot] <= commit.key;
      end
      if (do_value) begin
         value_mem[commit.slot] <= commit.value;
      end
      rd_key_ff   <= key_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

   // recency and occupancy update
   always_comb begin
      lkv_pkg::idx_type promo_rank;
      logic             evict_i;
      valid_in   = valid_ff;
      rank_in    = rank_ff;
      occ_in     = occ_ff;
      promo_rank = rank_ff[commit.slot];
      evict_i    = 1'b0;
      if (commit.valid) begin
         unique case (commit.op)
            lkv_pkg::OP_PROMOTE: begin
               // entries more recent than the hit move down one place
               for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                  if (valid_ff[i] && (rank_ff[i] < promo_rank)) begin
                     rank_in[i] = rank_ff[i] + lkv_pkg::IDX_W'(1);
                  end
               end
               rank_in[commit.slot] = '0;
            end
            lkv_pkg::OP_INSERT: begin
               // drop entries past capacity, age the rest, add the new one
               for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
                  evict_i = valid_ff[i] && commit.evict &&
                            (rank_ff[i] >= commit.cap_m1);
                  if (valid_ff[i] && !evict_i) begin
                     rank_in[i] = rank_ff[i] + lkv_pkg::IDX_W'(1);
                  end else begin
                     valid_in[i] = 1'b0;
                  end
               end
               valid_in[commit.slot] = 1'b1;
               rank_in[commit.slot]  = '0;
               occ_in = commit.count + lkv_pkg::CNT_W'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
      end
   end

   // ranks of free slots are don't care
   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
   end

   assign status.valid     = valid_ff;
   assign status.rank      = rank_ff;
   assign status.occupancy = occ_ff;

endmodule

>>> rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Sequencer that walks every slot through one key comparator, then commits
// the table update and, for a get, loads the response register.
// ----------------------------------------------------------------------------
module lkv_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   lkv_req_if.sink              req,
   lkv_rsp_if.source            rsp,
   input  lkv_pkg::idx_type     cap_m1,
   input  lkv_pkg::status_type  status,
   input  lkv_pkg::data_type    rd_key,
   input  lkv_pkg::data_type    rd_value,
   output lkv_pkg::idx_type     rd_addr,
   output lkv_pkg::commit_type  commit
);

   lkv_pkg::state_type state_ff, state_in;

   // captured request
   logic              cmd_ff, cmd_in;
   lkv_pkg::data_type key_ff, key_in;
   lkv_pkg::data_type val_ff, val_in;
   lkv_pkg::idx_type  cap_m1_ff, cap_m1_in;
   logic              evict_ff, evict_in;

   // walk position and compare stage
   lkv_pkg::idx_type  scan_idx_ff, scan_idx_in;
   logic              cmp_valid_ff, cmp_valid_in;
   lkv_pkg::idx_type  cmp_idx_ff, cmp_idx_in;

   // walk results
   logic              found_ff, found_in;
   lkv_pkg::idx_type  slot_ff, slot_in;
   lkv_pkg::data_type hit_value_ff, hit_value_in;
   logic              free_found_ff, free_found_in;
   lkv_pkg::idx_type  free_slot_ff, free_slot_in;
   lkv_pkg::cnt_type  count_ff, count_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   lkv_pkg::data_type rsp_value_ff, rsp_value_in;

   logic accept;
   logic last_slot;
   logic can_finish;
   logic slot_valid;
   logic slot_evict;
   logic slot_match;

   assign accept     = req.valid && req.ready;
   assign last_slot  = (scan_idx_ff == lkv_pkg::IDX_W'(lkv_pkg::ENTRIES - 1));
   assign can_finish = (cmd_ff == lkv_pkg::CMD_PUT) || !rsp_valid_ff || rsp.ready;

   // shared compare unit on the slot read last cycle
   assign slot_valid = status.valid[cmp_idx_ff];
   assign slot_evict = slot_valid && evict_ff && (status.rank[cmp_idx_ff] >= cap_m1_ff);
   assign slot_match = slot_valid && (rd_key == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lkv_pkg::ST_IDLE: begin
            if (req.valid) begin
               state_in = lkv_pkg::ST_SCAN;
            end
         end
         lkv_pkg::ST_SCAN: begin
            if (last_slot) begin
               state_in = lkv_pkg::ST_DRAIN;
            end
         end
         lkv_pkg::ST_DRAIN: begin
            state_in = lkv_pkg::ST_COMMIT;
         end
         lkv_pkg::ST_COMMIT: begin
            if (can_finish) begin
               state_in = lkv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lkv_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req.ready = (state_ff == lkv_pkg::ST_IDLE);
      rd_addr   = scan_idx_ff;

      commit.valid       = (state_ff == lkv_pkg::ST_COMMIT) && can_finish;
      commit.slot        = found_ff ? slot_ff : free_slot_ff;
      commit.key         = key_ff;
      commit.value       = val_ff;
      commit.write_value = (cmd_ff == lkv_pkg::CMD_PUT);
      commit.evict       = evict_ff;
      commit.cap_m1      = cap_m1_ff;
      commit.count       = count_ff;
      priority if (found_ff) begin
         commit.op = lkv_pkg::OP_PROMOTE;
      end else if ((cmd_ff == lkv_pkg::CMD_PUT) && free_found_ff) begin
         commit.op = lkv_pkg::OP_INSERT;
      end else begin
         commit.op = lkv_pkg::OP_NONE;
      end

      rsp.valid      = rsp_valid_ff;
      rsp.hit        = rsp_hit_ff;
      rsp.read_value = rsp_value_ff;
   end

   // request capture, walk bookkeeping and response register
   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      cap_m1_in     = cap_m1_ff;
      evict_in      = evict_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_valid_in  = (state_ff == lkv_pkg::ST_SCAN);
      cmp_idx_in    = scan_idx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      hit_value_in  = hit_value_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;

      if (accept) begin
         cmd_in        = req.command;
         key_in        = req.lookup_key;
         val_in        = req.store_value;
         cap_m1_in     = cap_m1;
         evict_in      = status.occupancy > lkv_pkg::CNT_W'(cap_m1);
         scan_idx_in   = '0;
         found_in      = 1'b0;
         free_found_in = 1'b0;
         count_in      = '0;
      end

      if (state_ff == lkv_pkg::ST_SCAN) begin
         scan_idx_in = scan_idx_ff + lkv_pkg::IDX_W'(1);
      end

      if (cmp_valid_ff) begin
         if (slot_match && !found_ff) begin
            found_in     = 1'b1;
            slot_in      = cmp_idx_ff;
            hit_value_in = rd_value;
         end
         if ((!slot_valid || slot_evict) && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = cmp_idx_ff;
         end
         if (slot_valid && !slot_evict) begin
            count_in = count_ff + lkv_pkg::CNT_W'(1);
         end
      end

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit.valid && (cmd_ff == lkv_pkg::CMD_GET)) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = found_ff;
         rsp_value_in = found_ff ? hit_value_ff : lkv_pkg::MISS_VALUE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::ST_IDLE;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      cap_m1_ff     <= cap_m1_in;
      evict_ff      <= evict_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      hit_value_ff  <= hit_value_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      count_ff      <= count_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
   end

endmodule

>>> rtl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries a request: command (get or put), lookup_key and
//   store_value. A get returns one response on rsp_bus (hit, read_value,
//   read_value is -1 on a miss); a put returns nothing.
//   csr_write_enable/csr_write_data set the capacity (zero acts as one,
//   values above the slot count saturate). Write it only while idle.
// Walk:
//   Each request walks all ENTRIES slots through one key comparator, one
//   slot per cycle from the key memory read port, then drains the compare
//   stage and commits. A get response is registered at the commit; the
//   next request is accepted only after the previous one has committed.
// Reset:
//   Synchronous; empties the store and sets capacity to 16. No clearing
//   pass is needed, valid bits are flops.
// Stalls:
//   A response waits in the output register while rsp_bus.ready is low. A
//   following request is still taken and walked; if it is a get, its commit
//   waits until the output register is free.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
   input  logic                  clock,
   input  logic                  reset,
   lkv_req_if.sink               req_bus,
   lkv_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  lkv_pkg::cap_type      csr_write_data
);

   lkv_pkg::cap_type    cap_ff, cap_in;
   lkv_pkg::idx_type    cap_m1;
   lkv_pkg::status_type status;
   lkv_pkg::commit_type commit;
   lkv_pkg::idx_type    rd_addr;
   lkv_pkg::data_type   rd_key;
   lkv_pkg::data_type   rd_value;

   // capacity register
   assign cap_in = csr_write_enable ? csr_write_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= lkv_pkg::CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   assign cap_m1 = lkv_pkg::eff_cap_m1(cap_ff);

   // sequencer
   lkv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .cap_m1   (cap_m1),
      .status   (status),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .rd_addr  (rd_addr),
      .commit   (commit)
   );

   // entry storage
   lkv_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .commit   (commit),
      .status   (status)
   );

`ifndef SYNTHESIS
   // busy for the whole walk after taking a request
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while a walk was running");

   // occupancy tracks the number of valid slots
   assert property (@(posedge clock) disable iff (reset)
      $countones(status.valid) == int'(status.occupancy))
      else $error("occupancy does not match valid slots");

   // an insert never lands on a slot that stays valid without eviction
   assert property (@(posedge clock) disable iff (reset)
      (commit.valid && (commit.op == lkv_pkg::OP_INSERT) && !commit.evict)
      |-> !status.valid[commit.slot])
      else $error("insert overwrote a live slot");
`endif

endmodule
